### rtl/core/omrs_pkg.sv
// Shared constants, request codes and controller/datapath handshake types
// for the ordered multiset rank/select unit. No dependencies.
package omrs_pkg;

  localparam int DISTINCT_CAP = 1024;
  localparam int COUNT_BITS   = 20;
  localparam int AW           = $clog2(DISTINCT_CAP);
  localparam int UW           = $clog2(DISTINCT_CAP + 1);
  localparam int SUM_W        = COUNT_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] HELD_MAX  =
    (COUNT_BITS >= 31) ? COUNT_BITS'(32'h7FFF_FFFE) : COUNT_MAX;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_RANK   = 3'd2;
  localparam logic [2:0] OP_KTH    = 3'd3;
  localparam logic [2:0] OP_PRED   = 3'd4;
  localparam logic [2:0] OP_SUCC   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  typedef struct packed {
    logic start;
    logic scan_go;
    logic up_init;
    logic up_go;
    logic dn_init;
    logic dn_go;
    logic commit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_idle;
    logic up_idle;
    logic need_up;
    logic need_dn;
    logic need_commit;
  } sts_t;

endpackage

### rtl/core/omrs_if.sv
// Request and response channel interfaces for the rank/select unit.
// Depends on nothing; payload widths are fixed by the field list.
interface omrs_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface omrs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic [1:0]         status;
  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

### rtl/core/ordered_multiset_rank_select_unit.sv
// Top level of the ordered multiset rank/select unit: controller plus
// datapath. Depends on omrs_pkg, omrs_req_if, omrs_rsp_if, omrs_ctrl, omrs_datapath.
//
//   Channel  Direction  Payload
//   req      in         op[2:0], value[31:0] signed
//   rsp      out        result[31:0] signed, status[1:0]
//
// A query scans every stored entry; an insert or delete that shifts the sorted
// store also moves the entries above its position one at a time, since the
// key/count memory has a single read port.
// Reset is synchronous and empties the store at once; no clearing pass runs.
// A response waits in its register while rsp is stalled; the next request is
// taken as soon as the previous one has reached that register.
module ordered_multiset_rank_select_unit (
  input  logic       clk,
  input  logic       rst,
  omrs_req_if.sink   req,
  omrs_rsp_if.source rsp
);
  import omrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  omrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  omrs_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_op      (req.op),
    .in_value   (req.value),
    .sts        (sts),
    .res        (rsp.result),
    .res_status (rsp.status)
  );

endmodule

### rtl/core/omrs_datapath.sv
// Datapath: sorted key and count memories, scan accumulators, shift logic
// and the result register. Depends on omrs_pkg.
module omrs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  omrs_pkg::cmd_t      cmd,
  input  logic [2:0]          in_op,
  input  logic signed [31:0]  in_value,
  output omrs_pkg::sts_t      sts,
  output logic signed [31:0]  res,
  output logic [1:0]          res_status
);
  import omrs_pkg::*;

  typedef enum logic [1:0] {M_SCAN, M_UP, M_DN} mode_t;

  logic signed [31:0]    key_mem [DISTINCT_CAP];
  logic [COUNT_BITS-1:0] cnt_mem [DISTINCT_CAP];

  logic [2:0]            op;
  logic signed [31:0]    x;
  logic [UW-1:0]         used;
  logic [COUNT_BITS-1:0] total;
  logic [UW-1:0]         ptr;
  logic [UW-1:0]         p;
  logic                  found;
  logic                  committed;
  logic [COUNT_BITS-1:0] cnt_p;
  logic [SUM_W-1:0]      sum;
  logic signed [31:0]    pred_key, succ_key, kth_key;
  logic                  pred_ok, succ_ok, kth_ok;
  logic [COUNT_BITS-1:0] k_rem;

  logic                  rd_vld;
  mode_t                 rd_mode;
  logic [AW-1:0]         ent;
  logic signed [31:0]    rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  mode_t                 rd_mode_next;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic signed [31:0]    wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic                  ins_full, ins_ok, del_ok, drop_entry;
  logic                  kth_range;

  assign ins_full = (total >= HELD_MAX) ||
                    (found && cnt_p >= COUNT_MAX) ||
                    (!found && used >= UW'(DISTINCT_CAP));
  assign ins_ok     = (op == OP_INSERT) && !ins_full;
  assign del_ok     = (op == OP_DELETE) && found;
  assign drop_entry = del_ok && (cnt_p == COUNT_BITS'(1));

  assign sts.scan_idle   = (ptr >= used) && !rd_vld;
  assign sts.up_idle     = (ptr == p) && !rd_vld;
  assign sts.need_up     = ins_ok && !found;
  assign sts.need_dn     = drop_entry;
  assign sts.need_commit = ins_ok || del_ok;

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = ptr[AW-1:0];
    rd_mode_next = M_SCAN;
    if (cmd.scan_go && ptr < used) begin
      rd_en = 1'b1;
    end else if (cmd.dn_go && ptr < used) begin
      rd_en        = 1'b1;
      rd_mode_next = M_DN;
    end else if (cmd.up_go && ptr > p) begin
      rd_en        = 1'b1;
      rd_addr      = AW'(ptr - UW'(1));
      rd_mode_next = M_UP;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ent;
    wr_key  = rd_key;
    wr_cnt  = rd_cnt;
    if (rd_vld && rd_mode == M_UP) begin
      wr_en   = 1'b1;
      wr_addr = ent + AW'(1);
    end else if (rd_vld && rd_mode == M_DN) begin
      wr_en   = 1'b1;
      wr_addr = ent - AW'(1);
    end else if (cmd.commit && !drop_entry) begin
      wr_en   = 1'b1;
      wr_addr = p[AW-1:0];
      wr_key  = x;
      if (op == OP_DELETE) begin
        wr_cnt = cnt_p - COUNT_BITS'(1);
      end else if (found) begin
        wr_cnt = cnt_p + COUNT_BITS'(1);
      end else begin
        wr_cnt = COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_cnt <= cnt_mem[rd_addr];
      ent    <= rd_addr;
    end
  end

  assign kth_range = (x > 32'sd0) && ({1'b0, x} <= $signed({1'b0, 32'(total)}));

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      total   <= '0;
      rd_vld  <= 1'b0;
      rd_mode <= M_SCAN;
      ptr     <= '0;
    end else begin
      rd_vld  <= rd_en;
      rd_mode <= rd_mode_next;
      if (cmd.start) begin
        op        <= in_op;
        x         <= in_value;
        k_rem     <= in_value[COUNT_BITS-1:0];
        ptr       <= '0;
        p         <= '0;
        found     <= 1'b0;
        committed <= 1'b0;
        cnt_p     <= '0;
        sum       <= '0;
        pred_ok   <= 1'b0;
        succ_ok   <= 1'b0;
        kth_ok    <= 1'b0;
      end else if (cmd.up_init) begin
        ptr <= used;
      end else if (cmd.dn_init) begin
        ptr <= p + UW'(1);
      end else if (rd_en) begin
        if (rd_mode_next == M_UP) begin
          ptr <= ptr - UW'(1);
        end else begin
          ptr <= ptr + UW'(1);
        end
      end
      if (rd_vld && rd_mode == M_SCAN) begin
        if (rd_key < x) begin
          sum      <= sum + SUM_W'(rd_cnt);
          pred_key <= rd_key;
          pred_ok  <= 1'b1;
          p        <= UW'(ent) + UW'(1);
        end
        if (rd_key == x) begin
          found <= 1'b1;
          cnt_p <= rd_cnt;
        end
        if (rd_key > x && !succ_ok) begin
          succ_key <= rd_key;
          succ_ok  <= 1'b1;
        end
        if (!kth_ok) begin
          if (k_rem <= rd_cnt) begin
            kth_key <= rd_key;
            kth_ok  <= 1'b1;
          end else begin
            k_rem <= k_rem - rd_cnt;
          end
        end
      end
      if (cmd.commit) begin
        committed <= 1'b1;
        if (op == OP_INSERT) begin
          total <= total + COUNT_BITS'(1);
          if (!found) begin
            used <= used + UW'(1);
          end
        end else begin
          total <= total - COUNT_BITS'(1);
          if (drop_entry) begin
            used <= used - UW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res        <= '0;
      res_status <= ST_OK;
      case (op)
        OP_INSERT: res_status <= committed ? ST_OK : ST_FULL;
        OP_DELETE: res_status <= found ? ST_OK : ST_ABSENT;
        OP_RANK:   res <= 32'(sum + SUM_W'(1));
        OP_KTH: begin
          if (kth_range && kth_ok) begin
            res <= kth_key;
          end else begin
            res_status <= ST_NONE;
          end
        end
        OP_PRED: begin
          if (pred_ok) begin
            res <= pred_key;
          end else begin
            res_status <= ST_NONE;
          end
        end
        OP_SUCC: begin
          if (succ_ok) begin
            res <= succ_key;
          end else begin
            res_status <= ST_NONE;
          end
        end
        default: res_status <= ST_NONE;
      endcase
    end
  end

  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(DISTINCT_CAP)) else $error("distinct count over capacity");
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    total <= HELD_MAX) else $error("held total over limit");
  a_scan_nowrite: assert property (@(posedge clk) disable iff (rst)
    (rd_vld && rd_mode == M_SCAN) |-> !wr_en) else $error("write during scan");
  a_commit_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !rd_vld) else $error("commit while shift in flight");

endmodule

### rtl/core/omrs_ctrl.sv
// Controller: sequences scan, shift, commit and response phases of a
// request and drives the channel handshakes. Depends on omrs_pkg.
module omrs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  omrs_pkg::sts_t sts,
  output omrs_pkg::cmd_t cmd
);
  import omrs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_UP, S_DN, S_COMMIT, S_FIN}
    state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.start = in_valid;
      S_SCAN:   cmd.scan_go = 1'b1;
      S_DECIDE: begin
        cmd.up_init = sts.need_up;
        cmd.dn_init = sts.need_dn;
      end
      S_UP:     cmd.up_go = 1'b1;
      S_DN:     cmd.dn_go = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_FIN:    cmd.finish = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_idle) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts.need_up) begin
            state <= S_UP;
          end else if (sts.need_dn) begin
            state <= S_DN;
          end else if (sts.need_commit) begin
            state <= S_COMMIT;
          end else begin
            state <= S_FIN;
          end
        end
        S_UP: begin
          if (sts.up_idle) state <= S_COMMIT;
        end
        S_DN: begin
          if (sts.scan_idle) state <= S_COMMIT;
        end
        S_COMMIT: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan_go, cmd.up_go, cmd.dn_go, cmd.commit, cmd.finish}))
    else $error("overlapping phase commands");
  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finished response not presented");
  a_busy_noaccept: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !in_ready) else $error("second request taken while busy");

endmodule

### sim/ordered_multiset_rank_select_unit_tb.sv
// Self-checking testbench for the ordered multiset rank/select unit.
// Depends on omrs_pkg, omrs_req_if, omrs_rsp_if and the unit's top level.
`timescale 1ns / 1ps

module ordered_multiset_rank_select_unit_tb;
  import omrs_pkg::*;

  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic signed [31:0] result;
    logic [1:0]         status;
  } answer_t;

  class multiset_scoreboard;
    logic signed [31:0]     keys[$];
    logic [COUNT_BITS-1:0]  cnts[$];
    int unsigned            held;
    answer_t                answers[$];

    function int unsigned lower_pos(logic signed [31:0] x);
      int unsigned i;
      i = 0;
      while (i < keys.size() && keys[i] < x) i++;
      return i;
    endfunction

    function void note_request(logic [2:0] op, logic signed [31:0] x);
      answer_t     a;
      int unsigned p;
      int unsigned q;
      bit          found;
      longint      k;
      longint      sum;
      p = lower_pos(x);
      found = (p < keys.size()) && (keys[p] == x);
      a.result = '0;
      a.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held >= HELD_MAX) a.status = ST_FULL;
          else if (found) begin
            if (cnts[p] == COUNT_MAX) a.status = ST_FULL;
            else begin
              cnts[p]++;
              held++;
            end
          end else if (keys.size() >= DISTINCT_CAP) a.status = ST_FULL;
          else begin
            keys.insert(p, x);
            cnts.insert(p, 1);
            held++;
          end
        end
        OP_DELETE: begin
          if (!found) a.status = ST_ABSENT;
          else begin
            cnts[p]--;
            held--;
            if (cnts[p] == 0) begin
              keys.delete(p);
              cnts.delete(p);
            end
          end
        end
        OP_RANK: begin
          sum = 1;
          for (int i = 0; i < p; i++) sum += cnts[i];
          a.result = sum[31:0];
        end
        OP_KTH: begin
          if (x < 1 || x > held) a.status = ST_NONE;
          else begin
            k = x;
            foreach (keys[i]) begin
              if (k <= cnts[i]) begin
                a.result = keys[i];
                break;
              end
              k -= cnts[i];
            end
          end
        end
        OP_PRED: begin
          if (p > 0) a.result = keys[p-1];
          else a.status = ST_NONE;
        end
        OP_SUCC: begin
          q = found ? p + 1 : p;
          if (q < keys.size()) a.result = keys[q];
          else a.status = ST_NONE;
        end
        default: a.status = ST_NONE;
      endcase
      answers.push_back(a);
    endfunction

    function string check_result(logic signed [31:0] result, logic [1:0] status);
      answer_t a;
      if (answers.size() == 0) return "response with no request outstanding";
      a = answers.pop_front();
      if (result !== a.result || status !== a.status)
        return $sformatf("got result %0d status %0d, expected %0d status %0d",
                         result, status, a.result, a.status);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int errors = 0;
  bit idle_on = 1'b1;
  multiset_scoreboard sb = new();

  omrs_req_if req ();
  omrs_rsp_if rsp ();

  ordered_multiset_rank_select_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.op = OP_INSERT;
    req.value = '0;
    rsp.ready = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    string msg;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ordered_multiset_rank_select_unit verification failed");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      msg = sb.check_result(rsp.result, rsp.status);
      if (msg != "") report(msg);
    end
    rsp.ready <= rst ? 1'b0 : !(idle_on && $urandom_range(99) < 36);
  end

  task automatic send(logic [2:0] op, logic signed [31:0] x);
    while (idle_on && $urandom_range(99) < 36) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.value <= x;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(op, x);
  endtask

  task automatic drain();
    while (sb.answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $signed($urandom_range(40)) - 20;
    if (r < 75) return sb.keys.size() ? sb.keys[$urandom_range(sb.keys.size() - 1)] : 0;
    if (r < 80) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom();
  endfunction

  task automatic random_request();
    int r;
    logic [2:0] op;
    logic signed [31:0] x;
    r = $urandom_range(99);
    if (r < 32) op = OP_INSERT;
    else if (r < 52) op = OP_DELETE;
    else if (r < 97) op = 3'($urandom_range(OP_SUCC, OP_RANK));
    else op = 3'($urandom_range(7, 6));
    x = pick_value();
    if (op == OP_KTH && $urandom_range(9) < 8) x = $urandom_range(sb.held + 2);
    send(op, x);
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_RANK, 32'sh8000_0000);
    send(OP_KTH, 1);
    send(OP_PRED, 0);
    send(OP_SUCC, 0);
    send(OP_DELETE, 5);
    send(3'd6, 1);
    send(3'd7, -1);
    send(OP_INSERT, 32'sh8000_0000);
    send(OP_INSERT, 32'sh7FFF_FFFF);
    send(OP_INSERT, 0);
    send(OP_INSERT, 0);
    send(OP_INSERT, -7);
    send(OP_RANK, 0);
    send(OP_RANK, 32'sh7FFF_FFFF);
    send(OP_KTH, 0);
    send(OP_KTH, -3);
    send(OP_KTH, 3);
    send(OP_KTH, 6);
    send(OP_PRED, 32'sh8000_0000);
    send(OP_PRED, 1);
    send(OP_SUCC, 32'sh7FFF_FFFF);
    send(OP_SUCC, 0);
    send(OP_DELETE, 0);
    send(OP_DELETE, 32'sh7FFF_FFFF);
    send(OP_DELETE, 3);

    for (n = 0; n < 518; n++) begin
      idle_on = !(n >= 200 && n < 300);
      random_request();
      if (n == 400) begin
        req.valid <= 1'b0;
        drain();
        @(posedge clk);
      end
    end

    send(OP_INSERT, 32'sd999_999);
    send(OP_INSERT, sb.keys[0]);
    send(OP_KTH, sb.held);
    send(OP_RANK, 32'sh7FFF_FFFF);
    send(OP_PRED, 32'sh7FFF_FFFF);
    repeat (30) random_request();
    req.valid <= 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && sb.answers.size() == 0)
      $display("ordered_multiset_rank_select_unit verification clean");
    else
      $display("ordered_multiset_rank_select_unit verification failed");
    $finish;
  end
endmodule
